// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion shorthands, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GFO_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gradient offset assertion failed");

// next-cycle implication
`define GFO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gradient offset assertion failed");

`endif

// ----- sv/gfo_pkg.sv -----
// ----------------------------------------------------------------------------
// gfo_pkg
// types and constants shared by the gradient offset pipeline
// ----------------------------------------------------------------------------
package gfo_pkg;

    localparam int NUM_REGS = 8;
    localparam int AW       = 5;
    localparam int DXW      = 18;
    localparam int EXW      = 17;
    localparam int NW       = 36;
    localparam int DW       = 34;
    localparam int QW       = 64;
    localparam int RW       = 32;
    localparam int OW       = 17;
    localparam int LOWPAD   = QW - NW - 16;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_FILL_MODE    = 3'd2;
    localparam logic [2:0] REG_SPREAD_MODE  = 3'd3;
    localparam logic [2:0] REG_START_X      = 3'd4;
    localparam logic [2:0] REG_START_Y      = 3'd5;
    localparam logic [2:0] REG_END_X        = 3'd6;
    localparam logic [2:0] REG_END_Y        = 3'd7;

    localparam logic [1:0] MODE_LINEAR   = 2'd0;
    localparam logic [1:0] MODE_RADIAL   = 2'd1;
    localparam logic [1:0] MODE_SQUARE   = 2'd2;
    localparam logic [1:0] SPREAD_CLAMP  = 2'd0;
    localparam logic [1:0] SPREAD_REPEAT = 2'd1;
    localparam logic [1:0] SPREAD_MIRROR = 2'd2;

    localparam logic [OW-1:0] ONE_Q16 = 17'h10000;
    localparam logic [OW:0]   TWO_Q16 = 18'h20000;

    typedef struct packed {
        logic [14:0]        image_width;
        logic [14:0]        image_height;
        logic [1:0]         fill_mode;
        logic [1:0]         spread_mode;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
    } t_cfg;

endpackage

// ----- sv/gfo_apb_regs.sv -----
// ----------------------------------------------------------------------------
// gfo_apb_regs
// configuration register file behind a simple apb-style port
// ----------------------------------------------------------------------------
module gfo_apb_regs import gfo_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [AW-1:0] paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output t_cfg          o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[AW-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_IMAGE_WIDTH:  n_cfg.image_width  = pwdata[14:0];
                REG_IMAGE_HEIGHT: n_cfg.image_height = pwdata[14:0];
                REG_FILL_MODE:    n_cfg.fill_mode    = pwdata[1:0];
                REG_SPREAD_MODE:  n_cfg.spread_mode  = pwdata[1:0];
                REG_START_X:      n_cfg.start_x      = pwdata[15:0];
                REG_START_Y:      n_cfg.start_y      = pwdata[15:0];
                REG_END_X:        n_cfg.end_x        = pwdata[15:0];
                REG_END_Y:        n_cfg.end_y        = pwdata[15:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= 15'd64;
            r_cfg.image_height <= 15'd64;
            r_cfg.fill_mode    <= MODE_LINEAR;
            r_cfg.spread_mode  <= SPREAD_CLAMP;
            r_cfg.start_x      <= 16'sd0;
            r_cfg.start_y      <= 16'sd0;
            r_cfg.end_x        <= 16'sd4096;
            r_cfg.end_y        <= 16'sd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            REG_IMAGE_WIDTH:  prdata = {17'd0, r_cfg.image_width};
            REG_IMAGE_HEIGHT: prdata = {17'd0, r_cfg.image_height};
            REG_FILL_MODE:    prdata = {30'd0, r_cfg.fill_mode};
            REG_SPREAD_MODE:  prdata = {30'd0, r_cfg.spread_mode};
            REG_START_X:      prdata = {16'd0, r_cfg.start_x};
            REG_START_Y:      prdata = {16'd0, r_cfg.start_y};
            REG_END_X:        prdata = {16'd0, r_cfg.end_x};
            REG_END_Y:        prdata = {16'd0, r_cfg.end_y};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// ----- sv/gfo_div_pipe.sv -----
// ----------------------------------------------------------------------------
// gfo_div_pipe
// restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module gfo_div_pipe #(
    parameter int DIVW = 34,
    parameter int QBW  = 64,
    parameter int SW   = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [DIVW-1:0] i_divisor,
    input  logic [DIVW-1:0] i_rem,
    input  logic [QBW-1:0]  i_low,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [QBW-1:0]  o_quot,
    output logic [DIVW-1:0] o_rem,
    output logic [SW-1:0]   o_side
);

    logic            r_vld  [QBW];
    logic [DIVW-1:0] r_div  [QBW];
    logic [DIVW-1:0] r_rem  [QBW];
    logic [QBW-1:0]  r_lq   [QBW];
    logic [SW-1:0]   r_side [QBW];

    for (genvar s = 0; s < QBW; s++) begin : g_stage
        logic            a_vld;
        logic [DIVW-1:0] a_div;
        logic [DIVW-1:0] a_rem;
        logic [QBW-1:0]  a_lq;
        logic [SW-1:0]   a_side;
        logic [DIVW:0]   w_t;
        logic            w_ge;
        logic [DIVW-1:0] n_rem;
        logic [QBW-1:0]  n_lq;

        if (s == 0) begin : g_first
            assign a_vld  = i_valid;
            assign a_div  = i_divisor;
            assign a_rem  = i_rem;
            assign a_lq   = i_low;
            assign a_side = i_side;
        end else begin : g_next
            assign a_vld  = r_vld[s-1];
            assign a_div  = r_div[s-1];
            assign a_rem  = r_rem[s-1];
            assign a_lq   = r_lq[s-1];
            assign a_side = r_side[s-1];
        end

        assign w_t   = {a_rem, a_lq[QBW-1]};
        assign w_ge  = w_t >= {1'b0, a_div};
        assign n_rem = w_ge ? DIVW'(w_t - {1'b0, a_div}) : w_t[DIVW-1:0];
        assign n_lq  = {a_lq[QBW-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_div[s]  <= a_div;
            r_rem[s]  <= n_rem;
            r_lq[s]   <= n_lq;
            r_side[s] <= a_side;
        end
    end

    assign o_valid = r_vld[QBW-1];
    assign o_quot  = r_lq[QBW-1];
    assign o_rem   = r_rem[QBW-1];
    assign o_side  = r_side[QBW-1];

endmodule

// ----- sv/gfo_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// gfo_sqrt_pipe
// integer square root, one root bit per register stage
// ----------------------------------------------------------------------------
module gfo_sqrt_pipe #(
    parameter int RBW = 32,
    parameter int SW  = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [2*RBW-1:0] i_value,
    input  logic [SW-1:0]    i_side,
    output logic             o_valid,
    output logic [RBW-1:0]   o_root,
    output logic [SW-1:0]    o_side
);

    logic             r_vld  [RBW];
    logic [RBW+1:0]   r_rem  [RBW];
    logic [RBW-1:0]   r_root [RBW];
    logic [2*RBW-1:0] r_x    [RBW];
    logic [SW-1:0]    r_side [RBW];

    for (genvar s = 0; s < RBW; s++) begin : g_stage
        logic             a_vld;
        logic [RBW+1:0]   a_rem;
        logic [RBW-1:0]   a_root;
        logic [2*RBW-1:0] a_x;
        logic [SW-1:0]    a_side;
        logic [RBW+3:0]   w_rt;
        logic [RBW+3:0]   w_trial;
        logic             w_ge;
        logic [RBW+1:0]   n_rem;
        logic [RBW-1:0]   n_root;

        if (s == 0) begin : g_first
            assign a_vld  = i_valid;
            assign a_rem  = '0;
            assign a_root = '0;
            assign a_x    = i_value;
            assign a_side = i_side;
        end else begin : g_next
            assign a_vld  = r_vld[s-1];
            assign a_rem  = r_rem[s-1];
            assign a_root = r_root[s-1];
            assign a_x    = r_x[s-1];
            assign a_side = r_side[s-1];
        end

        assign w_rt    = {a_rem, a_x[2*RBW-1 -: 2]};
        assign w_trial = {2'b00, a_root, 2'b01};
        assign w_ge    = w_rt >= w_trial;
        assign n_rem   = w_ge ? (RBW+2)'(w_rt - w_trial) : w_rt[RBW+1:0];
        assign n_root  = {a_root[RBW-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem;
            r_root[s] <= n_root;
            r_x[s]    <= {a_x[2*RBW-3:0], 2'b00};
            r_side[s] <= a_side;
        end
    end

    assign o_valid = r_vld[RBW-1];
    assign o_root  = r_root[RBW-1];
    assign o_side  = r_side[RBW-1];

endmodule

// ----- sv/gradient_fill_offset_top.sv -----
// ----------------------------------------------------------------------------
// gradient_fill_offset_top
// gradient offset of one pixel: normalize, fill rule, spread rule
// ----------------------------------------------------------------------------
// Takes one pixel per clock; busy never rises, and each offset leaves on
// o_valid in order, one result per transaction. Each pixel passes through
// the bit-serial pipelines: FRAC_BITS + 1 stages of coordinate division,
// 64 stages of the shared offset divider and 32 stages of square root,
// plus six stages of input, multiply and spread logic. The result cannot
// be held off by the receiver, so it must take o_offset on the o_valid
// cycle. The user must write configuration only while no transaction is
// in flight; the block itself does not enforce this.
`include "assert_macros.svh"

module gradient_fill_offset_top import gfo_pkg::*; #(
    parameter int MAX_DIM   = 16384,
    parameter int FRAC_BITS = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [13:0]   i_pixel_x,
    input  logic [13:0]   i_pixel_y,
    output logic          o_valid,
    output logic [OW-1:0] o_offset,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [AW-1:0] paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int DVW = $clog2(MAX_DIM);
    localparam int NQW = FRAC_BITS + 1;

    t_cfg w_cfg;

    gfo_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign busy = 1'b0;

    // input stage: size saturation and coordinate clamp
    logic [14:0]    w_szx, w_szy;
    logic [DVW-1:0] w_dvx, w_dvy, w_pcx, w_pcy;
    logic           r_v0;
    logic [DVW-1:0] r_dvx, r_dvy, r_pcx, r_pcy;
    logic           r_zx, r_zy;

    always_comb begin
        w_szx = (w_cfg.image_width == 15'd0) ? 15'd1 : w_cfg.image_width;
        w_szy = (w_cfg.image_height == 15'd0) ? 15'd1 : w_cfg.image_height;
        if (32'(w_szx) > 32'(MAX_DIM)) begin
            w_dvx = DVW'(MAX_DIM - 1);
        end else begin
            w_dvx = DVW'(w_szx - 15'd1);
        end
        if (32'(w_szy) > 32'(MAX_DIM)) begin
            w_dvy = DVW'(MAX_DIM - 1);
        end else begin
            w_dvy = DVW'(w_szy - 15'd1);
        end
        if (32'(i_pixel_x) > 32'(w_dvx)) begin
            w_pcx = w_dvx;
        end else begin
            w_pcx = DVW'(i_pixel_x);
        end
        if (32'(i_pixel_y) > 32'(w_dvy)) begin
            w_pcy = w_dvy;
        end else begin
            w_pcy = DVW'(i_pixel_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvx <= w_dvx;
        r_dvy <= w_dvy;
        r_pcx <= w_pcx;
        r_pcy <= w_pcy;
        r_zx  <= (w_dvx == '0);
        r_zy  <= (w_dvy == '0);
    end

    // coordinate normalization
    logic           w_nvx, w_nvy;
    logic [NQW-1:0] w_qx, w_qy;
    logic [DVW-1:0] w_rx, w_ry;
    logic           w_zxo, w_zyo;

    gfo_div_pipe #(.DIVW(DVW), .QBW(NQW), .SW(1)) u_div_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_v0),
        .i_divisor (r_dvx),
        .i_rem     (r_pcx >> 1),
        .i_low     ({r_pcx[0], FRAC_BITS'(0)}),
        .i_side    (r_zx),
        .o_valid   (w_nvx),
        .o_quot    (w_qx),
        .o_rem     (w_rx),
        .o_side    (w_zxo)
    );

    gfo_div_pipe #(.DIVW(DVW), .QBW(NQW), .SW(1)) u_div_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_v0),
        .i_divisor (r_dvy),
        .i_rem     (r_pcy >> 1),
        .i_low     ({r_pcy[0], FRAC_BITS'(0)}),
        .i_side    (r_zy),
        .o_valid   (w_nvy),
        .o_quot    (w_qy),
        .o_rem     (w_ry),
        .o_side    (w_zyo)
    );

    // stage a: differences
    logic [NQW-1:0]        w_posx, w_posy;
    logic signed [DXW-1:0] r_dx, r_dy;
    logic signed [EXW-1:0] r_ex, r_ey;
    logic                  r_va;

    assign w_posx = w_zxo ? '0 : w_qx;
    assign w_posy = w_zyo ? '0 : w_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= w_nvx && w_nvy && (w_rx == w_rx) && (w_ry == w_ry);
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= $signed({{(DXW-NQW){1'b0}}, w_posx}) - DXW'(w_cfg.start_x);
        r_dy <= $signed({{(DXW-NQW){1'b0}}, w_posy}) - DXW'(w_cfg.start_y);
        r_ex <= EXW'(w_cfg.end_x) - EXW'(w_cfg.start_x);
        r_ey <= EXW'(w_cfg.end_y) - EXW'(w_cfg.start_y);
    end

    // stage b: products and magnitudes
    logic                    w_lin;
    logic signed [DXW-1:0]   w_mx, w_my;
    logic [DXW-1:0]          w_adx, w_ady;
    logic [EXW-1:0]          w_aex, w_aey;
    logic signed [2*DXW-1:0] r_pa, r_pb;
    logic signed [2*EXW-1:0] r_pc, r_pd;
    logic [DXW-1:0]          r_n;
    logic [EXW-1:0]          r_d;
    logic                    r_vb, r_zb;

    assign w_lin = (w_cfg.fill_mode == MODE_LINEAR);
    assign w_mx  = w_lin ? DXW'(r_ex) : r_dx;
    assign w_my  = w_lin ? DXW'(r_ey) : r_dy;
    assign w_adx = r_dx[DXW-1] ? DXW'(-r_dx) : DXW'(r_dx);
    assign w_ady = r_dy[DXW-1] ? DXW'(-r_dy) : DXW'(r_dy);
    assign w_aex = r_ex[EXW-1] ? EXW'(-r_ex) : EXW'(r_ex);
    assign w_aey = r_ey[EXW-1] ? EXW'(-r_ey) : EXW'(r_ey);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa <= r_dx * w_mx;
        r_pb <= r_dy * w_my;
        r_pc <= r_ex * r_ex;
        r_pd <= r_ey * r_ey;
        r_n  <= (w_adx > w_ady) ? w_adx : w_ady;
        r_d  <= (w_aex > w_aey) ? w_aex : w_aey;
        r_zb <= (r_ex == '0) && (r_ey == '0);
    end

    // stage c: numerator and denominator for the shared divider
    logic signed [NW:0] w_num;
    logic [NW-1:0]      w_nn;
    logic [DW-1:0]      w_den;
    logic               w_neg;
    logic [DW-1:0]      r_dd, r_rem0;
    logic [QW-1:0]      r_low;
    logic [2:0]         r_sidec;
    logic               r_vc;

    assign w_num = (NW+1)'(r_pa) + (NW+1)'(r_pb);

    always_comb begin
        w_nn  = '0;
        w_den = DW'(1);
        w_neg = 1'b0;
        if (!r_zb) begin
            case (w_cfg.fill_mode)
                MODE_LINEAR: begin
                    w_neg = w_num[NW];
                    w_nn  = w_num[NW] ? NW'(-w_num) : NW'(w_num);
                    w_den = DW'(r_pc) + DW'(r_pd);
                end
                MODE_RADIAL: begin
                    w_nn  = NW'(w_num);
                    w_den = DW'(r_pc) + DW'(r_pd);
                end
                MODE_SQUARE: begin
                    w_nn  = NW'(r_n);
                    w_den = DW'(r_d);
                end
                default: begin
                    w_nn  = '0;
                    w_den = DW'(1);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else begin
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dd <= w_den;
        if (w_cfg.fill_mode == MODE_RADIAL) begin
            r_rem0     <= DW'(w_nn[NW-1:32]);
            r_low      <= {w_nn[31:0], 32'd0};
            r_sidec[1] <= DW'(w_nn[NW-1:32]) >= w_den;
        end else begin
            r_rem0     <= '0;
            r_low      <= {LOWPAD'(0), w_nn, 16'd0};
            r_sidec[1] <= 1'b0;
        end
        r_sidec[2] <= r_zb;
        r_sidec[0] <= w_neg;
    end

    // shared offset divider
    logic          w_dv;
    logic [QW-1:0] w_q;
    logic [DW-1:0] w_r;
    logic [2:0]    w_sd;

    gfo_div_pipe #(.DIVW(DW), .QBW(QW), .SW(3)) u_div_t (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_vc),
        .i_divisor (r_dd),
        .i_rem     (r_rem0),
        .i_low     (r_low),
        .i_side    (r_sidec),
        .o_valid   (w_dv),
        .o_quot    (w_q),
        .o_rem     (w_r),
        .o_side    (w_sd)
    );

    // stage e: floor correction and saturation
    logic [QW-1:0] w_qs, w_m;
    logic [QW-1:0] r_qe;
    logic [19:0]   r_sidee;
    logic          r_ve;

    assign w_qs = w_sd[1] ? '1 : w_q;
    assign w_m  = w_sd[0] ? (w_qs + QW'(w_r != '0)) : w_qs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else begin
            r_ve <= w_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_qe    <= w_qs;
        r_sidee <= {w_sd[2], w_sd[0],
                    (w_m[QW-1:OW] != '0) || (w_m[OW-1:0] > ONE_Q16), w_m[OW-1:0]};
    end

    // radial square root
    logic          w_sv;
    logic [RW-1:0] w_root;
    logic [19:0]   w_ss;

    gfo_sqrt_pipe #(.RBW(RW), .SW(20)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_ve),
        .i_value (r_qe),
        .i_side  (r_sidee),
        .o_valid (w_sv),
        .o_root  (w_root),
        .o_side  (w_ss)
    );

    // stage f: spread
    logic          w_neg_f, w_big_f, w_zero_f;
    logic [OW-1:0] w_low_f, n_offset;
    logic [OW-1:0] r_offset;
    logic          r_valid;

    always_comb begin
        w_zero_f = w_ss[19];
        if (w_cfg.fill_mode == MODE_RADIAL) begin
            w_neg_f = 1'b0;
            w_big_f = (w_root[RW-1:OW] != '0) || (w_root[OW-1:0] > ONE_Q16);
            w_low_f = w_root[OW-1:0];
        end else begin
            w_neg_f = w_ss[18];
            w_big_f = w_ss[17];
            w_low_f = w_ss[OW-1:0];
        end
        case (w_cfg.spread_mode)
            SPREAD_REPEAT: begin
                n_offset = w_neg_f ? {1'b0, 16'(-w_low_f[15:0])} : {1'b0, w_low_f[15:0]};
            end
            SPREAD_MIRROR: begin
                n_offset = (w_low_f > ONE_Q16) ? OW'(TWO_Q16 - {1'b0, w_low_f}) : w_low_f;
            end
            default: begin
                n_offset = w_neg_f ? '0 : (w_big_f ? ONE_Q16 : w_low_f);
            end
        endcase
        if (w_zero_f) begin
            n_offset = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_offset <= n_offset;
    end

    assign o_valid  = r_valid;
    assign o_offset = r_offset;

    logic w_flat;
    assign w_flat = (w_cfg.start_x == w_cfg.end_x) && (w_cfg.start_y == w_cfg.end_y);

    `GFO_ASSERT_IMPL(a_offset_range, o_valid, o_offset <= ONE_Q16)
    `GFO_ASSERT_IMPL(a_repeat_below_one, o_valid && (w_cfg.spread_mode == SPREAD_REPEAT), !o_offset[16])
    `GFO_ASSERT_IMPL(a_flat_gradient, o_valid && w_flat, o_offset == '0)
    `GFO_ASSERT_NEXT(a_root_to_output, w_sv, o_valid)

endmodule
